### rtl/vrpva_pkg.sv
// Package for the video register port: payload structs, constants, queue entry type.
// No dependencies.
package vrpva_pkg;

    localparam int VramDepth  = 16384;
    localparam int VramAw     = $clog2(VramDepth);
    localparam int OamDepth   = 256;
    localparam int OamAw      = $clog2(OamDepth);
    localparam int PalDepth   = 32;
    localparam int PalAw      = 5;
    localparam logic [16:0] SUPPRESS_RESET = 17'd89341;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OADDR  = 3'd3;
    localparam logic [2:0] REG_ODATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  reg_index;
        logic [7:0]  write_data;
        logic [16:0] frame_cycle;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_line;
        logic        a12_rise;
        logic        vblank_suppressed;
        logic [14:0] vram_address;
        logic [2:0]  fine_x;
        logic [2:0]  emphasis;
    } out_item_t;

    // Classified access handed from front to back.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_REG,
        OP_STATUS,
        OP_OAM_RD,
        OP_DATA_RD,
        OP_DATA_WR,
        OP_EVENT
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        is_write;
        logic [2:0]  reg_index;
        logic [7:0]  data;
        logic        sup_hit;
        logic        early_cycle;
    } cmd_t;

    // Back end sequencer states.
    typedef enum logic [1:0] { ST_IDLE, ST_MEM, ST_DONE } bstate_t;

endpackage

### rtl/vrpva_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module vrpva_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/vrpva_front.sv
// Front end: accepts bus accesses, classifies them, compares cycle to suppress point.
// Depends on vrpva_pkg.
module vrpva_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vrpva_pkg::in_item_t in_item,
    input  logic [16:0]        suppress_cycle,
    output logic               cmd_valid,
    output vrpva_pkg::cmd_t    cmd,
    input  logic               cmd_take
);
    import vrpva_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;

    assign full      = valid_reg && !cmd_take;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next = cmd_reg;
        valid_next = valid_reg && !cmd_take;
        if (push && !full)
        begin
            valid_next = 1'b1;
            cmd_next.reg_index   = in_item.reg_index;
            cmd_next.data        = in_item.write_data;
            cmd_next.is_write    = (in_item.req_type == REQ_WRITE);
            cmd_next.sup_hit     = (in_item.frame_cycle == suppress_cycle);
            cmd_next.early_cycle = (in_item.frame_cycle[16:1] == 16'd0);
            unique case (in_item.req_type)
                REQ_READ:
                begin
                    case (in_item.reg_index)
                        REG_STATUS: cmd_next.op = OP_STATUS;
                        REG_ODATA:  cmd_next.op = OP_OAM_RD;
                        REG_DATA:   cmd_next.op = OP_DATA_RD;
                        default:    cmd_next.op = OP_REG;
                    endcase
                end
                REQ_WRITE:
                    cmd_next.op = (in_item.reg_index == REG_DATA) ? OP_DATA_WR : OP_REG;
                REQ_EVENT: cmd_next.op = OP_EVENT;
                default:   cmd_next.op = OP_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> valid_reg)
        else $error("full without a held command");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !cmd_take) |=> ($stable(cmd_reg) && valid_reg))
        else $error("held command changed");
    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> valid_reg)
        else $error("command taken while none held");
endmodule

### rtl/vrpva_back.sv
// Back end: register file, address latches and memory ports; sequencer with idle, memory and done states.
// Depends on vrpva_pkg and vrpva_ram.
module vrpva_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  vrpva_pkg::cmd_t      cmd,
    output logic                 cmd_take,
    output logic                 empty,
    input  logic                 pop,
    output vrpva_pkg::out_item_t out_item
);
    import vrpva_pkg::*;

    bstate_t state_reg, state_next;
    cmd_t    cur_reg, cur_next;
    logic [7:0]  ctrl_reg, ctrl_next, mask_reg, mask_next, rbuf_reg, rbuf_next;
    logic [7:0]  fetch_reg, fetch_next, optr_reg, optr_next, rdata_reg, rdata_next;
    logic [2:0]  flags_reg, flags_next, fine_reg, fine_next;
    logic [14:0] t_reg, t_next, v_reg, v_next;
    logic        toggle_reg, toggle_next, lrd12_reg, lrd12_next, lwr12_reg, lwr12_next;
    logic        nmi_reg, nmi_next, sup_reg, sup_next, rise_reg, rise_next;
    logic [13:0] acc_reg, acc_next;

    logic              vram_we, oam_we, pal_all;
    logic              pal_we [PalDepth];
    logic [7:0]        vram_q, oam_q;
    logic [7:0]        pal_reg [PalDepth];
    logic [14:0]       step;

    vrpva_ram #(.Width(8), .Depth(VramDepth)) u_vram (
        .clk(clk), .we(vram_we), .addr(v_reg[VramAw-1:0]), .wdata(cur_next.data),
        .rdata(vram_q));
    vrpva_ram #(.Width(8), .Depth(OamDepth)) u_oam (
        .clk(clk), .we(oam_we), .addr(optr_reg), .wdata(cur_next.data), .rdata(oam_q));

    assign step     = ctrl_reg[2] ? 15'd32 : 15'd1;
    assign cmd_take = cmd_valid && (state_reg == ST_IDLE);
    assign empty    = (state_reg != ST_DONE);

    always_comb
    begin
        out_item.read_data         = rdata_reg;
        out_item.nmi_line          = nmi_reg;
        out_item.a12_rise          = rise_reg;
        out_item.vblank_suppressed = sup_reg;
        out_item.vram_address      = v_reg;
        out_item.fine_x            = fine_reg;
        out_item.emphasis          = mask_reg[7:5];
    end

    always_comb
    begin
        state_next = state_reg;   cur_next = cur_reg;
        ctrl_next = ctrl_reg;     mask_next = mask_reg;   rbuf_next = rbuf_reg;
        fetch_next = fetch_reg;   optr_next = optr_reg;   rdata_next = rdata_reg;
        flags_next = flags_reg;   fine_next = fine_reg;   t_next = t_reg;
        v_next = v_reg;           toggle_next = toggle_reg;
        lrd12_next = lrd12_reg;   lwr12_next = lwr12_reg;
        nmi_next = nmi_reg;       sup_next = sup_reg;     rise_next = rise_reg;
        acc_next = acc_reg;
        vram_we = 1'b0;           oam_we = 1'b0;          pal_all = 1'b0;
        for (int i = 0; i < PalDepth; i++)
        begin
            pal_we[i] = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next   = cmd;
                    rdata_next = 8'd0;
                    rise_next  = 1'b0;
                    state_next = ST_DONE;
                    unique case (cmd.op)
                        OP_REG:
                        begin
                            if (!cmd.is_write)
                            begin
                                rdata_next = rbuf_reg;
                            end
                            else
                            begin
                                case (cmd.reg_index)
                                    REG_CTRL:
                                    begin
                                        ctrl_next = cmd.data;
                                        nmi_next  = cmd.data[7];
                                        t_next[11:10] = cmd.data[1:0];
                                    end
                                    REG_MASK:  mask_next = cmd.data;
                                    REG_OADDR: optr_next = cmd.data;
                                    REG_ODATA:
                                    begin
                                        oam_we    = 1'b1;
                                        optr_next = optr_reg + 8'd1;
                                    end
                                    REG_SCROLL:
                                    begin
                                        if (!toggle_reg)
                                        begin
                                            t_next[4:0] = cmd.data[7:3];
                                            fine_next   = cmd.data[2:0];
                                        end
                                        else
                                        begin
                                            t_next[9:5]   = cmd.data[7:3];
                                            t_next[14:12] = cmd.data[2:0];
                                        end
                                        toggle_next = !toggle_reg;
                                    end
                                    REG_ADDR:
                                    begin
                                        if (!toggle_reg)
                                        begin
                                            t_next[14:8] = {1'b0, cmd.data[5:0]};
                                        end
                                        else
                                        begin
                                            t_next[7:0] = cmd.data;
                                            v_next      = {t_reg[14:8], cmd.data};
                                        end
                                        toggle_next = !toggle_reg;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        OP_STATUS:
                        begin
                            if (cmd.sup_hit)
                            begin
                                sup_next = 1'b1;
                                nmi_next = 1'b0;
                            end
                            if (cmd.early_cycle)
                            begin
                                nmi_next = 1'b0;
                            end
                            rdata_next     = {flags_reg, rbuf_reg[4:0]};
                            flags_next[2]  = 1'b0;
                            toggle_next    = 1'b0;
                        end
                        OP_OAM_RD: state_next = ST_MEM;
                        OP_DATA_RD:
                        begin
                            // wrap, then issue the memory read at the wrapped address
                            v_next     = {1'b0, v_reg[13:0]};
                            acc_next   = v_reg[13:0];
                            rise_next  = !lrd12_reg && v_reg[12];
                            lrd12_next = v_reg[12];
                            state_next = ST_MEM;
                        end
                        OP_DATA_WR:
                        begin
                            rise_next  = !lwr12_reg && v_reg[12];
                            lwr12_next = v_reg[12];
                            if (v_reg < 15'h3F00)
                            begin
                                vram_we = 1'b1;
                            end
                            else if (v_reg[3:0] == 4'd0)
                            begin
                                pal_all = 1'b1;
                            end
                            else if (v_reg[1:0] != 2'd0)
                            begin
                                pal_we[v_reg[4:0]] = 1'b1;
                            end
                            v_next = {1'b0, 14'(v_reg + step)};
                        end
                        OP_EVENT: flags_next = cmd.data[7:5];
                        default: ;
                    endcase
                end
            end
            ST_MEM:
            begin
                state_next = ST_DONE;
                if (cur_reg.op == OP_OAM_RD)
                begin
                    rdata_next = oam_q;
                end
                else
                begin
                    fetch_next = vram_q;
                    if (acc_reg[13:8] == 6'h3F)
                    begin
                        rbuf_next  = pal_reg[acc_reg[4:0]];
                        rdata_next = pal_reg[acc_reg[4:0]];
                    end
                    else
                    begin
                        rbuf_next  = fetch_reg;
                        rdata_next = fetch_reg;
                    end
                    v_next = 15'({1'b0, acc_reg} + step);
                end
            end
            ST_DONE:
            begin
                if (pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;   ctrl_reg <= '0;   mask_reg <= '0;   rbuf_reg <= '0;
            fetch_reg <= '0;        optr_reg <= '0;   flags_reg <= '0;  fine_reg <= '0;
            t_reg <= '0;            v_reg <= '0;      toggle_reg <= 1'b0;
            lrd12_reg <= 1'b0;      lwr12_reg <= 1'b0;
            nmi_reg <= 1'b0;        sup_reg <= 1'b0;  rise_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; ctrl_reg <= ctrl_next; mask_reg <= mask_next;
            rbuf_reg <= rbuf_next;   fetch_reg <= fetch_next; optr_reg <= optr_next;
            flags_reg <= flags_next; fine_reg <= fine_next; t_reg <= t_next;
            v_reg <= v_next;         toggle_reg <= toggle_next;
            lrd12_reg <= lrd12_next; lwr12_reg <= lwr12_next;
            nmi_reg <= nmi_next;     sup_reg <= sup_next;   rise_reg <= rise_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        rdata_reg <= rdata_next;
        acc_reg   <= acc_next;
        for (int i = 0; i < PalDepth; i++)
        begin
            if (pal_we[i] || (pal_all && (i % 4 == 0)))
            begin
                pal_reg[i] <= cur_next.data;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEM) |=> (state_reg == ST_DONE))
        else $error("memory step did not finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !pop) |=> (state_reg == ST_DONE && $stable(rdata_reg)))
        else $error("result changed while waiting");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !cmd_take)
        else $error("command taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sup_reg) |-> !nmi_reg)
        else $error("suppression left NMI enabled");
endmodule

### rtl/video_register_port_vram_access.sv
// Top level of the video register port: front classifier, one-entry queue, back end.
// Depends on vrpva_pkg, vrpva_front, vrpva_back.
// The result is registered when the back end enters its done state: directly from idle for most
// items, and through the memory state for data port and sprite data reads.
// The back end sequencer holds one item at a time and takes no new one until its result is popped.
// The front holds one classified item, so a push is taken while a result waits.
// Reset (rst_n low, async) clears the control and state registers (not the held command, result data,
// access address or palette registers); suppress_cycle returns to 89341. Memories have no reset; no clearing pass.
module video_register_port_vram_access (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  vrpva_pkg::in_item_t  in_item,
    output logic                 empty,
    input  logic                 pop,
    output vrpva_pkg::out_item_t out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [16:0]          cfg_data
);
    import vrpva_pkg::*;

    logic [16:0] sup_cycle_reg;
    logic        cmd_valid, cmd_take;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sup_cycle_reg <= SUPPRESS_RESET;
        end
        else if (cfg_valid)
        begin
            sup_cycle_reg <= cfg_data;
        end
    end

    vrpva_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .suppress_cycle(sup_cycle_reg), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take));

    vrpva_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .out_item(out_item));
endmodule

### tb/sv/testbench.sv
// Testbench for video_register_port_vram_access: register accesses, data port bursts,
// status reads and flag events, checked field by field against an in-bench predictor.
// Depends on vrpva_pkg and the RTL top level.
module testbench;
    import vrpva_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    in_item_t   in_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    out_item_t  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [16:0] cfg_data = '0;

    video_register_port_vram_access uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state
    bit [7:0]  vram_m [VramDepth];
    bit        vram_w [VramDepth];
    bit [7:0]  pal_m [PalDepth];
    bit        pal_w [PalDepth];
    bit [7:0]  oam_m [OamDepth];
    bit        oam_w [OamDepth];
    bit [16:0] sup_cycle = SUPPRESS_RESET;
    bit [7:0]  ctrl_r, mask_r, rbuf, flatch, sprite_ptr;
    bit [2:0]  stat_r, fine_r;
    bit [14:0] tmp_addr, cur_addr, last_rd_addr, last_wr_addr;
    bit        toggle_r, nmi_r, sup_r;

    in_item_t  pend_items[$];
    out_item_t pend_results[$];
    out_item_t due_results[$];
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        mismatch_count = 0;
    int        item_count = 0;

    function automatic out_item_t predict_access(in_item_t it);
        out_item_t o;
        bit [14:0] a;
        bit [7:0]  d;
        o = '0;
        d = it.write_data;
        if (it.req_type == REQ_READ) begin
            case (it.reg_index)
                REG_STATUS:
                begin
                    if (it.frame_cycle == sup_cycle)
                    begin
                        sup_r = 1'b1;
                        nmi_r = 1'b0;
                    end
                    if (it.frame_cycle < 2)
                        nmi_r = 1'b0;
                    o.read_data = {stat_r, rbuf[4:0]};
                    stat_r[2] = 1'b0;
                    toggle_r = 1'b0;
                end
                REG_ODATA: o.read_data = oam_m[sprite_ptr];
                REG_DATA:
                begin
                    rbuf = flatch;
                    a = cur_addr & 15'h3FFF;
                    if (!last_rd_addr[12] && a[12])
                        o.a12_rise = 1'b1;
                    last_rd_addr = a;
                    flatch = vram_m[a[13:0]];
                    if (a[13:8] == 6'h3F)
                        rbuf = pal_m[a[4:0]];
                    cur_addr = a + (ctrl_r[2] ? 15'd32 : 15'd1);
                    o.read_data = rbuf;
                end
                default: o.read_data = rbuf;
            endcase
        end else if (it.req_type == REQ_WRITE) begin
            case (it.reg_index)
                REG_CTRL:
                begin
                    ctrl_r = d;
                    nmi_r = d[7];
                    tmp_addr[11:10] = d[1:0];
                end
                REG_MASK: mask_r = d;
                REG_OADDR: sprite_ptr = d;
                REG_ODATA:
                begin
                    oam_m[sprite_ptr] = d;
                    oam_w[sprite_ptr] = 1'b1;
                    sprite_ptr = sprite_ptr + 8'd1;
                end
                REG_SCROLL:
                begin
                    if (!toggle_r)
                    begin
                        tmp_addr[4:0] = d[7:3];
                        fine_r = d[2:0];
                    end else begin
                        tmp_addr[9:5] = d[7:3];
                        tmp_addr[14:12] = d[2:0];
                    end
                    toggle_r = ~toggle_r;
                end
                REG_ADDR:
                begin
                    if (!toggle_r)
                    begin
                        tmp_addr[14] = 1'b0;
                        tmp_addr[13:8] = d[5:0];
                    end else begin
                        tmp_addr[7:0] = d;
                        cur_addr = tmp_addr;
                    end
                    toggle_r = ~toggle_r;
                end
                REG_DATA:
                begin
                    a = cur_addr;
                    if (!last_wr_addr[12] && a[12])
                        o.a12_rise = 1'b1;
                    last_wr_addr = a;
                    if (a < 15'h3F00)
                    begin
                        vram_m[a[13:0]] = d;
                        vram_w[a[13:0]] = 1'b1;
                    end else if (a[3:0] == 4'd0) begin
                        for (int i = 0; i < PalDepth; i += 4)
                        begin
                            pal_m[i] = d;
                            pal_w[i] = 1'b1;
                        end
                    end else if (a[1:0] != 2'd0) begin
                        pal_m[a[4:0]] = d;
                        pal_w[a[4:0]] = 1'b1;
                    end
                    cur_addr = (a + (ctrl_r[2] ? 15'd32 : 15'd1)) & 15'h3FFF;
                end
                default: ;
            endcase
        end else if (it.req_type == REQ_EVENT) begin
            stat_r = d[7:5];
        end
        o.nmi_line = nmi_r;
        o.vblank_suppressed = sup_r;
        o.vram_address = cur_addr;
        o.fine_x = fine_r;
        o.emphasis = mask_r[7:5];
        return o;
    endfunction

    // Queue one access unless it would read memory that was never written.
    function automatic void queue_access(bit [1:0] kind, bit [2:0] idx, bit [7:0] d,
                                         bit [16:0] fc);
        in_item_t  it;
        bit [13:0] a;
        a = cur_addr[13:0];
        if (kind == REQ_READ && idx == REG_ODATA && !oam_w[sprite_ptr])
            return;
        if (kind == REQ_READ && idx == REG_DATA &&
            (!vram_w[a] || (a[13:8] == 6'h3F && !pal_w[a[4:0]])))
            return;
        it.req_type = kind;
        it.reg_index = idx;
        it.write_data = d;
        it.frame_cycle = fc;
        pend_results.push_back(predict_access(it));
        pend_items.push_back(it);
        if (kind != 2'd3 && !(kind == REQ_WRITE && idx == REG_STATUS))
            item_count++;
    endfunction

    function automatic bit [16:0] rnd_cycle();
        return 17'($urandom());
    endfunction

    function automatic bit [16:0] status_cycle();
        case ($urandom_range(3))
            0: return sup_cycle;
            1: return 17'd0;
            2: return 17'd1;
            default: return rnd_cycle();
        endcase
    endfunction

    function automatic void set_address(bit [7:0] hi, bit [7:0] lo);
        queue_access(REQ_WRITE, REG_ADDR, hi, rnd_cycle());
        queue_access(REQ_WRITE, REG_ADDR, lo, rnd_cycle());
    endfunction

    function automatic void directed_items();
        queue_access(REQ_WRITE, REG_CTRL, 8'h83, rnd_cycle());
        queue_access(REQ_WRITE, REG_MASK, 8'hE0, rnd_cycle());
        queue_access(REQ_WRITE, REG_SCROLL, 8'hFF, rnd_cycle());
        queue_access(REQ_WRITE, REG_SCROLL, 8'h00, rnd_cycle());
        queue_access(REQ_READ, REG_STATUS, 8'h00, 17'd0);
        set_address(8'h3F, 8'h00);
        // palette: mirrored fill, direct entries, then an ignored slot
        for (int i = 0; i < 5; i++)
            queue_access(REQ_WRITE, REG_DATA, 8'hAA ^ 8'(i), rnd_cycle());
        set_address(8'hFF, 8'hFF);
        queue_access(REQ_WRITE, REG_DATA, 8'h5A, rnd_cycle());
        queue_access(REQ_WRITE, REG_DATA, 8'hA5, rnd_cycle());
        set_address(8'h0F, 8'hFF);
        queue_access(REQ_READ, REG_DATA, 8'h00, rnd_cycle());
        queue_access(REQ_READ, REG_DATA, 8'h00, 17'h1FFFF);
        queue_access(REQ_WRITE, REG_STATUS, 8'hFF, rnd_cycle());
        queue_access(REQ_EVENT, REG_STATUS, 8'hE0, rnd_cycle());
        queue_access(REQ_READ, REG_STATUS, 8'h00, sup_cycle);
        queue_access(REQ_WRITE, REG_OADDR, 8'hFF, rnd_cycle());
        queue_access(REQ_WRITE, REG_ODATA, 8'h00, rnd_cycle());
        queue_access(REQ_READ, REG_ODATA, 8'h00, rnd_cycle());
        queue_access(2'd3, 3'd7, 8'hFF, 17'h1FFFF);
    endfunction

    function automatic void random_items(int target);
        int        n;
        bit [7:0]  hi, lo;
        target += item_count;
        while (item_count < target)
        begin
            n = $urandom_range(1, 8);
            case ($urandom_range(99)) inside
                [0:34]:
                begin
                    case ($urandom_range(4))
                        0: hi = 8'($urandom());
                        1: hi = 8'h0F;
                        2: hi = 8'h10;
                        3: hi = 8'h3E;
                        default: hi = 8'h3F;
                    endcase
                    lo = 8'($urandom());
                    if (toggle_r)
                        queue_access(REQ_READ, REG_STATUS, 8'h00, rnd_cycle());
                    set_address(hi, lo);
                    repeat (n) queue_access(REQ_WRITE, REG_DATA, 8'($urandom()), rnd_cycle());
                    set_address(hi, lo);
                    repeat (n + 1) queue_access(REQ_READ, REG_DATA, 8'($urandom()),
                                                rnd_cycle());
                end
                [35:44]: queue_access(REQ_WRITE, REG_CTRL, 8'($urandom()), rnd_cycle());
                [45:49]: queue_access(REQ_WRITE, REG_MASK, 8'($urandom()), rnd_cycle());
                [50:57]:
                begin
                    queue_access(REQ_WRITE, REG_SCROLL, 8'($urandom()), rnd_cycle());
                    queue_access(REQ_WRITE, REG_SCROLL, 8'($urandom()), rnd_cycle());
                end
                [58:65]:
                begin
                    lo = 8'($urandom());
                    queue_access(REQ_WRITE, REG_OADDR, lo, rnd_cycle());
                    repeat (n) queue_access(REQ_WRITE, REG_ODATA, 8'($urandom()), rnd_cycle());
                    queue_access(REQ_WRITE, REG_OADDR, lo, rnd_cycle());
                    queue_access(REQ_READ, REG_ODATA, 8'($urandom()), rnd_cycle());
                end
                [66:75]: queue_access(REQ_READ, REG_STATUS, 8'($urandom()), status_cycle());
                [76:81]: queue_access(REQ_EVENT, 3'($urandom()), 8'($urandom()), rnd_cycle());
                [82:87]: queue_access(REQ_READ, 3'($urandom()), 8'($urandom()),
                                      status_cycle());
                [88:94]: queue_access(REQ_WRITE, 3'($urandom()), 8'($urandom()), rnd_cycle());
                default: queue_access(2'($urandom()), 3'($urandom()), 8'($urandom()),
                                      rnd_cycle());
            endcase
        end
    endfunction

    task automatic write_suppress(bit [16:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sup_cycle = value;
    endtask

    task automatic drain();
        while (pend_items.size() || due_results.size())
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Sender: advance through pending items; hold an item until its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push)
            begin
                void'(pend_items.pop_front());
                due_results.push_back(pend_results.pop_front());
            end
            if (pend_items.size() && $urandom_range(99) >= idle_pct)
            begin
                push <= 1'b1;
                in_item <= pend_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Receiver: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && pop && !empty)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with no expectation waiting");
                mismatch_count++;
            end else begin
                e = due_results.pop_front();
                check_field("read_data", e.read_data, out_item.read_data);
                check_field("nmi_line", e.nmi_line, out_item.nmi_line);
                check_field("a12_rise", e.a12_rise, out_item.a12_rise);
                check_field("vblank_suppressed", e.vblank_suppressed,
                            out_item.vblank_suppressed);
                check_field("vram_address", e.vram_address, out_item.vram_address);
                check_field("fine_x", e.fine_x, out_item.fine_x);
                check_field("emphasis", e.emphasis, out_item.emphasis);
            end
        end
        pop <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        bit [16:0] settings[5];
        int        idles[5];
        int        stalls[5];
        settings = '{17'h1FFFF, 17'd0, 17'd1, 17'd0, SUPPRESS_RESET};
        settings[3] = 17'($urandom());
        idles = '{0, 63, 0, 12, 0};
        stalls = '{0, 0, 63, 12, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        drain();
        for (int p = 0; p < 5; p++)
        begin
            idle_pct = idles[p];
            stall_pct = stalls[p];
            write_suppress(settings[p]);
            random_items(305);
            drain();
        end
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
